/* rtl/fde_pkg.sv */
// Shared constants, types and helper functions for the feedback delay echo.
// Used by the channel interfaces, the output queue and the top level.
// Depends on nothing else.
package fde_pkg;

	localparam int unsigned DEPTH    = 65536;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned SAMPLE_W = 16;

	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned FB_W     = 15;
	localparam int unsigned MIX_W    = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned FB_MAX   = 31129;
	localparam int unsigned MIX_ONE  = 32768;
	localparam int unsigned HALF_LSB = 16384;
	localparam int unsigned Q_SHIFT  = 15;

	localparam int unsigned DELAY_RESET_RAW = 4410;
	localparam int unsigned DELAY_RESET =
		(DELAY_RESET_RAW > DEPTH - 1) ? DEPTH - 1 : DELAY_RESET_RAW;

	localparam int unsigned MIXG_W     = MIX_W + 1;
	localparam int unsigned PROD_FB_W  = SAMPLE_W + FB_W + 1;
	localparam int unsigned PROD_MIX_W = SAMPLE_W + MIXG_W + 1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CFG_IDX_W-1:0] reg_index_t;

	localparam reg_index_t REG_DELAY    = 2'd0;
	localparam reg_index_t REG_FEEDBACK = 2'd1;
	localparam reg_index_t REG_MIX      = 2'd2;

	// Saturate a wide signed value to the signed sample range.
	function automatic sample_t sat_sample(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return sample_t'(hi);
		end else if (v < lo) begin
			return sample_t'(lo);
		end
		return sample_t'(v);
	endfunction

endpackage

/* rtl/fde_stream_if.sv */
// Valid/ready channel interfaces for input samples and echo results.
// Depends on fde_pkg for the sample width.
interface fde_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [fde_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface fde_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [fde_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/fde_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing else.
module fde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/fde_out_queue.sv */
// Small result queue that decouples the echo pipeline from the output channel.
// Depends on fde_pkg and fde_stream_if.
module fde_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fde_pkg::sample_t push_data,
	fde_result_if.source     result_ch
);
	import fde_pkg::*;

	sample_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    head_q;
	logic [QUEUE_AW-1:0]    tail_q;
	logic [QUEUE_CW-1:0]    count_q;
	logic                   pop;

	assign result_ch.valid      = (count_q != '0);
	assign result_ch.sample_out = entry_q[head_q];
	assign pop                  = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/feedback_delay_echo.sv */
// Feedback delay echo: top level with configuration registers and the delay pipeline.
// Depends on fde_pkg, fde_stream_if, fde_ram and fde_out_queue.
//
// The block takes one signed sample transaction per clock cycle while fewer than four
// accepted transactions await the taking of their results, and returns one echo sample
// per transaction. The rate is set by the read-modify-write loop through the single
// delay memory: the delayed sample is read in the accept cycle, and the feedback result
// is written back in the following cycle, with a bypass register covering a read of the
// entry written in that same cycle. A four-entry result queue lets the input keep
// flowing while results wait. The memory needs no clearing pass after reset: entries
// are written in index order, so an entry not yet written since reset reads as zero by
// comparing its address with the write index. Configuration must be written while idle.
module feedback_delay_echo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  fde_pkg::reg_index_t      cfg_index,
	input  logic [fde_pkg::CFG_W-1:0] cfg_data,
	fde_sample_if.sink               sample_ch,
	fde_result_if.source             result_ch
);
	import fde_pkg::*;

	addr_t                  delay_q;
	logic [FB_W-1:0]        fb_q;
	logic [MIX_W-1:0]       mix_q;

	addr_t                  wr_idx_q;
	logic                   wrapped_q;
	logic [QUEUE_CW-1:0]    inflight_q;

	logic                   accept;
	logic                   pop;
	addr_t                  rd_addr;
	logic                   entry_ok;
	logic [DELAY_W-1:0]     delay_raw;

	logic                   v_s1;
	addr_t                  w_s1;
	addr_t                  r_s1;
	logic                   ok_s1;
	sample_t                x_s1;

	logic                   fwd_v_q;
	addr_t                  fwd_addr_q;
	sample_t                fwd_data_q;

	logic [SAMPLE_W-1:0]    ram_rdata;
	sample_t                delayed;
	logic signed [PROD_FB_W-1:0]        fb_prod;
	logic signed [PROD_FB_W:0]          fb_biased;
	logic signed [PROD_FB_W-Q_SHIFT:0]  fb_term;
	logic signed [PROD_FB_W-Q_SHIFT+1:0] fb_total;
	sample_t                stored;

	logic [MIXG_W-1:0]      wet_g;
	logic [MIXG_W-1:0]      dry_g;
	logic signed [PROD_MIX_W-1:0] dry_prod;
	logic signed [PROD_MIX_W-1:0] wet_prod;

	logic                   v_s2;
	logic signed [PROD_MIX_W-1:0] dry_prod_s2;
	logic signed [PROD_MIX_W-1:0] wet_prod_s2;
	logic signed [PROD_MIX_W:0]   mix_sum;
	logic signed [PROD_MIX_W-Q_SHIFT:0] mix_term;
	sample_t                y_s2;

	// Configuration registers, clamped to their legal ranges on write.
	assign delay_raw = cfg_data[DELAY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= ADDR_W'(DELAY_RESET);
			fb_q    <= '0;
			mix_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY: begin
					if (delay_raw == '0) begin
						delay_q <= ADDR_W'(1);
					end else if (32'(delay_raw) > 32'(DEPTH - 1)) begin
						delay_q <= ADDR_W'(DEPTH - 1);
					end else begin
						delay_q <= ADDR_W'(delay_raw);
					end
				end
				REG_FEEDBACK: begin
					fb_q <= (32'(cfg_data[FB_W-1:0]) > 32'(FB_MAX)) ?
						FB_W'(FB_MAX) : cfg_data[FB_W-1:0];
				end
				REG_MIX: begin
					mix_q <= (32'(cfg_data[MIX_W-1:0]) > 32'(MIX_ONE)) ?
						MIX_W'(MIX_ONE) : cfg_data[MIX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Accept stage: read address of the delayed sample and its written status.
	assign pop             = result_ch.valid && result_ch.ready;
	assign sample_ch.ready = (inflight_q < QUEUE_CW'(QUEUE_DEPTH));
	assign accept          = sample_ch.valid && sample_ch.ready;

	always_comb begin
		if (wr_idx_q >= delay_q) begin
			rd_addr = wr_idx_q - delay_q;
		end else begin
			rd_addr = ADDR_W'({1'b0, wr_idx_q} + (ADDR_W + 1)'(DEPTH) - {1'b0, delay_q});
		end
		entry_ok = wrapped_q || (rd_addr < wr_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			wrapped_q  <= 1'b0;
			inflight_q <= '0;
		end else begin
			if (accept) begin
				if (wr_idx_q == ADDR_W'(DEPTH - 1)) begin
					wr_idx_q  <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			unique case ({accept, pop})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		w_s1  <= wr_idx_q;
		r_s1  <= rd_addr;
		ok_s1 <= entry_ok;
		x_s1  <= sample_ch.sample_in;
	end

	fde_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (w_s1),
		.wdata (stored),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Stage 1: delayed sample with bypass, feedback write-back and mix products.
	always_comb begin
		if (fwd_v_q && (fwd_addr_q == r_s1)) begin
			delayed = fwd_data_q;
		end else if (ok_s1) begin
			delayed = sample_t'(ram_rdata);
		end else begin
			delayed = '0;
		end
		fb_prod   = delayed * $signed({1'b0, fb_q});
		fb_biased = (PROD_FB_W + 1)'(fb_prod) + (PROD_FB_W + 1)'(HALF_LSB);
		fb_term   = $signed(fb_biased[PROD_FB_W:Q_SHIFT]);
		fb_total  = (PROD_FB_W - Q_SHIFT + 2)'(x_s1) + (PROD_FB_W - Q_SHIFT + 2)'(fb_term);
		stored    = sat_sample(64'(fb_total));

		wet_g    = MIXG_W'(mix_q);
		dry_g    = MIXG_W'(MIX_ONE) - wet_g;
		dry_prod = x_s1 * $signed({1'b0, dry_g});
		wet_prod = delayed * $signed({1'b0, wet_g});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			fwd_v_q <= v_s1;
			v_s2    <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q  <= w_s1;
		fwd_data_q  <= stored;
		dry_prod_s2 <= dry_prod;
		wet_prod_s2 <= wet_prod;
	end

	// Stage 2: blend, round half up and saturate into the result queue.
	always_comb begin
		mix_sum  = (PROD_MIX_W + 1)'(dry_prod_s2) + (PROD_MIX_W + 1)'(wet_prod_s2)
			+ (PROD_MIX_W + 1)'(HALF_LSB);
		mix_term = $signed(mix_sum[PROD_MIX_W:Q_SHIFT]);
		y_s2     = sat_sample(64'(mix_term));
	end

	fde_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (y_s2),
		.result_ch (result_ch)
	);

endmodule
